@@ rtl/core/fwr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package fwr_pkg;

  // Store geometry.
  localparam int DEPTH  = 32;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  // Fixed field widths of the item ports.
  localparam int DATA_W = 32;
  localparam int OP_W   = 2;
  localparam int POS_W  = 5;
  localparam int REM_W  = 6;
  localparam int STAT_W = 2;

  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic signed [DATA_W-1:0] data_t;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 2'd0,
    OP_REMOVE = 2'd1,
    OP_LIST   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  // One write port and one read port of the entry store.
  typedef struct packed {
    logic  wr_en;
    idx_t  wr_addr;
    data_t wr_data;
    logic  rd_en;
    idx_t  rd_addr;
  } mem_req_t;

endpackage

`default_nettype wire

@@ rtl/core/fwr_mem.sv @@
`timescale 1ns / 1ps
`default_nettype none

module fwr_mem (
  input  wire logic             clk,
  input  wire fwr_pkg::mem_req_t req,
  output      fwr_pkg::data_t   rd_data
);
  import fwr_pkg::*;

  data_t mem_r [DEPTH];
  data_t rd_data_r;

  // Read data is registered and holds while no read is issued.
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem_r[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem_r[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

@@ rtl/core/fifo_with_remove_by_value_top.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake             Payload
// in_       in_valid / in_ready   in_op, in_value
// out_      out_valid / out_ready out_item_value, out_position, out_removed_count,
//                                 out_status, out_last
//
// Append, clear and every request on an empty store give their single result item
// through ST_RESP, which loads the output register. Remove-matching makes one pass
// of the store read through one comparator over the N stored entries.
// List gives one item per cycle after the first entry is read, while out_ready is high.
// Reset empties the store at once; no clearing pass is needed since only entries
// below the fill count are ever read. The block takes a new item only when idle;
// a stalled output holds its item in the output register and pauses a listing.

module fifo_with_remove_by_value_top (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output      logic                                in_ready,
  input  wire logic [fwr_pkg::OP_W-1:0]            in_op,
  input  wire logic signed [fwr_pkg::DATA_W-1:0]   in_value,
  output      logic                                out_valid,
  input  wire logic                                out_ready,
  output      logic signed [fwr_pkg::DATA_W-1:0]   out_item_value,
  output      logic [fwr_pkg::POS_W-1:0]           out_position,
  output      logic [fwr_pkg::REM_W-1:0]           out_removed_count,
  output      logic [fwr_pkg::STAT_W-1:0]          out_status,
  output      logic                                out_last
);
  import fwr_pkg::*;

  // One-hot sequencer states.
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_RM   = 5'b00010,
    ST_LRD  = 5'b00100,
    ST_LOUT = 5'b01000,
    ST_RESP = 5'b10000
  } state_t;

  state_t   state_r, state_nxt;
  cnt_t     count_r, count_nxt;
  cnt_t     rd_idx_r, rd_idx_nxt;     // next entry to read during removal
  cnt_t     wr_idx_r, wr_idx_nxt;     // next slot to write during removal
  logic     pend_r, pend_nxt;         // read data of entry rd_idx_r - 1 is ready
  idx_t     idx_r, idx_nxt;           // entry being listed
  data_t    value_r, value_nxt;       // value to remove
  status_t  resp_status_r, resp_status_nxt;
  logic [REM_W-1:0] resp_removed_r, resp_removed_nxt;

  mem_req_t mem_req;
  data_t    rd_data;

  logic     slot_free;
  logic     out_load;
  data_t    load_value;
  logic [POS_W-1:0]  load_pos;
  logic [REM_W-1:0]  load_removed;
  status_t  load_status;
  logic     load_last;
  logic     rm_issue;
  logic     list_last;

  fwr_mem u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  assign in_ready  = (state_r == ST_IDLE);
  assign slot_free = !out_valid || out_ready;
  assign rm_issue  = (rd_idx_r != count_r);
  assign list_last = ((CNT_W'(idx_r) + CNT_W'(1)) == count_r);

  always_comb begin
    state_nxt        = state_r;
    count_nxt        = count_r;
    rd_idx_nxt       = rd_idx_r;
    wr_idx_nxt       = wr_idx_r;
    pend_nxt         = pend_r;
    idx_nxt          = idx_r;
    value_nxt        = value_r;
    resp_status_nxt  = resp_status_r;
    resp_removed_nxt = resp_removed_r;

    mem_req          = '0;

    out_load         = 1'b0;
    load_value       = '0;
    load_pos         = '0;
    load_removed     = '0;
    load_status      = STAT_OK;
    load_last        = 1'b1;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          resp_status_nxt  = STAT_OK;
          resp_removed_nxt = '0;
          state_nxt        = ST_RESP;
          if (op_t'(in_op) == OP_APPEND) begin
            if (count_r == CNT_W'(DEPTH)) begin
              resp_status_nxt = STAT_FULL;
            end else begin
              mem_req.wr_en   = 1'b1;
              mem_req.wr_addr = count_r[IDX_W-1:0];
              mem_req.wr_data = in_value;
              count_nxt       = count_r + CNT_W'(1);
            end
          end else if (count_r == '0) begin
            resp_status_nxt = STAT_EMPTY;
          end else begin
            unique case (op_t'(in_op))
              OP_REMOVE: begin
                value_nxt  = in_value;
                rd_idx_nxt = '0;
                wr_idx_nxt = '0;
                pend_nxt   = 1'b0;
                state_nxt  = ST_RM;
              end
              OP_LIST: begin
                idx_nxt   = '0;
                state_nxt = ST_LRD;
              end
              default: begin
                count_nxt = '0;
              end
            endcase
          end
        end
      end

      ST_RM: begin
        // Read ahead one entry while the previous one goes through the comparator.
        if (rm_issue) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = rd_idx_r[IDX_W-1:0];
          rd_idx_nxt      = rd_idx_r + CNT_W'(1);
        end
        pend_nxt = rm_issue;
        if (pend_r && (rd_data != value_r)) begin
          mem_req.wr_en   = 1'b1;
          mem_req.wr_addr = wr_idx_r[IDX_W-1:0];
          mem_req.wr_data = rd_data;
          wr_idx_nxt      = wr_idx_r + CNT_W'(1);
        end
        if (!rm_issue && !pend_r) begin
          count_nxt        = wr_idx_r;
          resp_removed_nxt = REM_W'(count_r - wr_idx_r);
          resp_status_nxt  = STAT_OK;
          state_nxt        = ST_RESP;
        end
      end

      ST_LRD: begin
        mem_req.rd_en   = 1'b1;
        mem_req.rd_addr = idx_r;
        state_nxt       = ST_LOUT;
      end

      ST_LOUT: begin
        if (slot_free) begin
          out_load   = 1'b1;
          load_value = rd_data;
          load_pos   = POS_W'(idx_r);
          load_last  = list_last;
          if (list_last) begin
            state_nxt = ST_IDLE;
          end else begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = idx_r + IDX_W'(1);
            idx_nxt         = idx_r + IDX_W'(1);
          end
        end
      end

      ST_RESP: begin
        if (slot_free) begin
          out_load     = 1'b1;
          load_removed = resp_removed_r;
          load_status  = resp_status_r;
          state_nxt    = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      count_r   <= '0;
      pend_r    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      pend_r    <= pend_nxt;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Working registers and the output payload need no reset.
  always_ff @(posedge clk) begin
    rd_idx_r       <= rd_idx_nxt;
    wr_idx_r       <= wr_idx_nxt;
    idx_r          <= idx_nxt;
    value_r        <= value_nxt;
    resp_status_r  <= resp_status_nxt;
    resp_removed_r <= resp_removed_nxt;
    if (out_load) begin
      out_item_value    <= load_value;
      out_position      <= load_pos;
      out_removed_count <= load_removed;
      out_status        <= load_status;
      out_last          <= load_last;
    end
  end

  // The fill count never passes the store depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("fill count above depth");

  // An accepted item always starts work, so the block is busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r != ST_IDLE))
    else $error("block idle right after accepting an item");

  // Compaction never writes ahead of the read pointer.
  a_rm_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RM) |-> ((wr_idx_r <= rd_idx_r) && (rd_idx_r <= count_r)))
    else $error("removal pointers out of order");

  // A listing only visits stored entries.
  a_list_range: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_LOUT) || (state_r == ST_LRD)) |-> (CNT_W'(idx_r) < count_r))
    else $error("listing beyond the fill count");

endmodule

`default_nettype wire
